@@ design/generational_handle_table_core_assert.svh @@
// assertion macros for the generational handle table core
// depends on a clk and an active-low rst_n in the including scope
`ifndef GENERATIONAL_HANDLE_TABLE_CORE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GHT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle table assertion failed");

// next-cycle implication, checked out of reset
`define GHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle table assertion failed");

`endif

@@ design/ght_pkg.sv @@
// shared types and constants for the generational handle table core
// no dependencies
package ght_pkg;

    localparam int GHT_ENTRIES  = 1024;
    localparam int GHT_GEN_BITS = 32;

    // operation codes
    localparam logic [2:0] FUNC_ALLOC   = 3'd0;
    localparam logic [2:0] FUNC_RELEASE = 3'd1;
    localparam logic [2:0] FUNC_QUERY   = 3'd2;
    localparam logic [2:0] FUNC_ATTACH  = 3'd3;
    localparam logic [2:0] FUNC_DETACH  = 3'd4;
    localparam logic [2:0] FUNC_READ    = 3'd5;

    // result status codes
    localparam logic [2:0] STATUS_OK     = 3'd0;
    localparam logic [2:0] STATUS_FULL   = 3'd1;
    localparam logic [2:0] STATUS_STALE  = 3'd2;
    localparam logic [2:0] STATUS_RANGE  = 3'd3;
    localparam logic [2:0] STATUS_NOCOMP = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_REL_CHK,
        S_REL_LAST,
        S_REL_FIX,
        S_REL_FREE,
        S_FLAG_CHK,
        S_LIST_RD,
        S_LIST_ENT
    } ght_state_t;

endpackage

@@ design/ght_ram.sv @@
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/generational_handle_table_core.sv @@
// top level of the generational handle table: sequencer plus three rams
// depends on ght_pkg, ght_ram and generational_handle_table_core_assert.svh
//
//  channel  | signals                                           | handshake
//  ---------+---------------------------------------------------+-------------------------
//  command  | func, entry_index, entry_generation, list_position | start && !busy
//  result   | status, handle_index, handle_generation,           | result_valid, one cycle
//           | has_component, live_count                         |
//
// one item at a time, result strobed in the cycle after the last step:
//   unknown func, full table, position out of range: answered from idle; allocate:
//   free stack read; query/attach/detach: entry read; read live slot: live list, entry;
//   release: dependent reads of entry ram, live list ram, then entry fix-ups on one port.
// after reset a clearing pass zeroes the entry ram and loads
// the free stack; busy stays high meanwhile. the receiver cannot stall results.
`include "generational_handle_table_core_assert.svh"

module generational_handle_table_core
    import ght_pkg::*;
#(
    parameter int ENTRIES         = GHT_ENTRIES,
    parameter int GENERATION_BITS = GHT_GEN_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   func,
    input  logic [$clog2(ENTRIES)-1:0]   entry_index,
    input  logic [GENERATION_BITS-1:0]   entry_generation,
    input  logic [$clog2(ENTRIES)-1:0]   list_position,
    output logic                         result_valid,
    output logic [2:0]                   status,
    output logic [$clog2(ENTRIES)-1:0]   handle_index,
    output logic [GENERATION_BITS-1:0]   handle_generation,
    output logic                         has_component,
    output logic [$clog2(ENTRIES)+1-1:0] live_count
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = IW + 1;
    localparam int GW = GENERATION_BITS;
    localparam int EW = GW + 1 + IW;
    localparam int FW = IW + GW;
    localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);
    localparam logic [GW-1:0] GEN_ONE   = GW'(1);

    // control registers
    ght_state_t    state_reg, state_next;
    logic [IW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0] fc_reg, fc_next;
    logic [CW-1:0] lt_reg, lt_next;
    logic          valid_reg, valid_next;

    // item and working registers
    logic [2:0]    func_reg, func_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [GW-1:0] gen_reg, gen_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [IW-1:0] last_reg, last_next;
    logic [GW-1:0] ngen_reg, ngen_next;

    // result registers
    logic [2:0]    status_reg, status_next;
    logic [IW-1:0] ridx_reg, ridx_next;
    logic [GW-1:0] rgen_reg, rgen_next;
    logic          rflag_reg, rflag_next;
    logic [CW-1:0] rcnt_reg, rcnt_next;

    // ram ports
    logic          ent_we, ll_we, fs_we;
    logic [IW-1:0] ent_waddr, ent_raddr, ll_waddr, ll_raddr, fs_waddr, fs_raddr;
    logic [EW-1:0] ent_wdata, ent_rdata;
    logic [IW-1:0] ll_wdata, ll_rdata;
    logic [FW-1:0] fs_wdata, fs_rdata;

    // fields of the entry read
    logic [GW-1:0] ent_gen;
    logic          ent_flag;
    logic [IW-1:0] ent_pos;
    logic          handle_ok;
    logic [CW-1:0] fc_dec, lt_dec, lt_inc;
    logic [GW-1:0] gen_inc;

    assign ent_gen  = ent_rdata[EW-1 -: GW];
    assign ent_flag = ent_rdata[IW];
    assign ent_pos  = ent_rdata[IW-1:0];
    assign fc_dec   = fc_reg - 1'b1;
    assign lt_dec   = lt_reg - 1'b1;
    assign lt_inc   = lt_reg + 1'b1;
    assign gen_inc  = ent_gen + 1'b1;

    // handle check against the entry just read
    assign handle_ok = (idx_reg != '0) && ({1'b0, idx_reg} < ENTRIES_C)
                       && (ent_gen != '0) && (ent_gen == gen_reg);

    ght_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_we),
        .wr_addr (ent_waddr),
        .wr_data (ent_wdata),
        .rd_addr (ent_raddr),
        .rd_data (ent_rdata)
    );

    ght_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_live_ram (
        .clk     (clk),
        .wr_en   (ll_we),
        .wr_addr (ll_waddr),
        .wr_data (ll_wdata),
        .rd_addr (ll_raddr),
        .rd_data (ll_rdata)
    );

    ght_ram #(.WIDTH(FW), .DEPTH(ENTRIES)) u_free_ram (
        .clk     (clk),
        .wr_en   (fs_we),
        .wr_addr (fs_waddr),
        .wr_data (fs_wdata),
        .rd_addr (fs_raddr),
        .rd_data (fs_rdata)
    );

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            fc_reg      <= CW'(ENTRIES - 1);
            lt_reg      <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            fc_reg      <= fc_next;
            lt_reg      <= lt_next;
            valid_reg   <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        idx_reg    <= idx_next;
        gen_reg    <= gen_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
        ngen_reg   <= ngen_next;
        status_reg <= status_next;
        ridx_reg   <= ridx_next;
        rgen_reg   <= rgen_next;
        rflag_reg  <= rflag_next;
        rcnt_reg   <= rcnt_next;
    end

    // sequencer: next state, ram accesses, result
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        fc_next      = fc_reg;
        lt_next      = lt_reg;
        valid_next   = 1'b0;
        func_next    = func_reg;
        idx_next     = idx_reg;
        gen_next     = gen_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        ngen_next    = ngen_reg;
        status_next  = status_reg;
        ridx_next    = ridx_reg;
        rgen_next    = rgen_reg;
        rflag_next   = rflag_reg;
        rcnt_next    = rcnt_reg;
        ent_we       = 1'b0;
        ent_waddr    = idx_reg;
        ent_wdata    = '0;
        ent_raddr    = idx_reg;
        ll_we        = 1'b0;
        ll_waddr     = pos_reg;
        ll_wdata     = last_reg;
        ll_raddr     = pos_reg;
        fs_we        = 1'b0;
        fs_waddr     = fc_reg[IW-1:0];
        fs_wdata     = {idx_reg, ngen_reg};
        fs_raddr     = fc_dec[IW-1:0];

        case (state_reg)
            // zero entries, load free stack with descending indices
            S_CLEAR:
            begin
                ent_we       = 1'b1;
                ent_waddr    = clr_cnt_reg;
                ent_wdata    = '0;
                fs_we        = 1'b1;
                fs_waddr     = clr_cnt_reg;
                fs_wdata     = {LAST_IDX - clr_cnt_reg, GEN_ONE};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end

            // take an item and start its first read
            S_IDLE:
            begin
                if (start)
                begin
                    func_next   = func;
                    idx_next    = entry_index;
                    gen_next    = entry_generation;
                    pos_next    = list_position;
                    status_next = STATUS_OK;
                    ridx_next   = '0;
                    rgen_next   = '0;
                    rflag_next  = 1'b0;
                    rcnt_next   = lt_reg;
                    ent_raddr   = entry_index;
                    ll_raddr    = list_position;
                    case (func)
                        FUNC_ALLOC:
                        begin
                            if (fc_reg == '0)
                            begin
                                status_next = STATUS_FULL;
                                valid_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = S_ALLOC_RD;
                            end
                        end
                        FUNC_RELEASE:
                        begin
                            state_next = S_REL_CHK;
                        end
                        FUNC_QUERY, FUNC_ATTACH, FUNC_DETACH:
                        begin
                            state_next = S_FLAG_CHK;
                        end
                        FUNC_READ:
                        begin
                            if ({1'b0, list_position} >= lt_reg)
                            begin
                                status_next = STATUS_RANGE;
                                valid_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LIST_RD;
                            end
                        end
                        default:
                        begin
                            valid_next = 1'b1;
                        end
                    endcase
                end
            end

            // popped handle: claim the entry and append it to the live list
            S_ALLOC_RD:
            begin
                ent_we     = 1'b1;
                ent_waddr  = fs_rdata[FW-1 -: IW];
                ent_wdata  = {fs_rdata[GW-1:0], 1'b0, lt_reg[IW-1:0]};
                ll_we      = 1'b1;
                ll_waddr   = lt_reg[IW-1:0];
                ll_wdata   = fs_rdata[FW-1 -: IW];
                fc_next    = fc_dec;
                lt_next    = lt_inc;
                ridx_next  = fs_rdata[FW-1 -: IW];
                rgen_next  = fs_rdata[GW-1:0];
                rcnt_next  = lt_inc;
                valid_next = 1'b1;
                state_next = S_IDLE;
            end

            // release: check handle, fetch the last live index
            S_REL_CHK:
            begin
                pos_next  = ent_pos;
                ngen_next = (gen_inc == '0) ? GEN_ONE : gen_inc;
                ll_raddr  = lt_dec[IW-1:0];
                if (!handle_ok || (lt_reg == '0))
                begin
                    status_next = STATUS_STALE;
                    valid_next  = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_REL_LAST;
                end
            end

            // move last into the hole, push the handle, read the moved entry
            S_REL_LAST:
            begin
                last_next  = ll_rdata;
                ll_we      = 1'b1;
                ll_waddr   = pos_reg;
                ll_wdata   = ll_rdata;
                fs_we      = 1'b1;
                ent_raddr  = ll_rdata;
                state_next = S_REL_FIX;
            end

            // repoint the moved entry at its new slot
            S_REL_FIX:
            begin
                ent_we     = (last_reg != idx_reg);
                ent_waddr  = last_reg;
                ent_wdata  = {ent_gen, ent_flag, pos_reg};
                state_next = S_REL_FREE;
            end

            // mark the released entry free
            S_REL_FREE:
            begin
                ent_we     = 1'b1;
                ent_waddr  = idx_reg;
                ent_wdata  = {{GW{1'b0}}, 1'b0, pos_reg};
                fc_next    = fc_reg + 1'b1;
                lt_next    = lt_dec;
                rcnt_next  = lt_dec;
                valid_next = 1'b1;
                state_next = S_IDLE;
            end

            // query, attach, detach
            S_FLAG_CHK:
            begin
                valid_next = 1'b1;
                state_next = S_IDLE;
                ent_waddr  = idx_reg;
                if (!handle_ok)
                begin
                    status_next = STATUS_STALE;
                end
                else
                begin
                    case (func_reg)
                        FUNC_ATTACH:
                        begin
                            ent_we     = 1'b1;
                            ent_wdata  = {ent_gen, 1'b1, ent_pos};
                            rflag_next = 1'b1;
                        end
                        FUNC_DETACH:
                        begin
                            if (ent_flag)
                            begin
                                ent_we    = 1'b1;
                                ent_wdata = {ent_gen, 1'b0, ent_pos};
                            end
                            else
                            begin
                                status_next = STATUS_NOCOMP;
                            end
                        end
                        default:
                        begin
                            rflag_next = ent_flag;
                        end
                    endcase
                end
            end

            // live slot read: index, then its entry
            S_LIST_RD:
            begin
                last_next  = ll_rdata;
                ent_raddr  = ll_rdata;
                state_next = S_LIST_ENT;
            end

            S_LIST_ENT:
            begin
                ridx_next  = last_reg;
                rgen_next  = ent_gen;
                rflag_next = ent_flag;
                valid_next = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy              = (state_reg != S_IDLE);
    assign result_valid      = valid_reg;
    assign status            = status_reg;
    assign handle_index      = ridx_reg;
    assign handle_generation = rgen_reg;
    assign has_component     = rflag_reg;
    assign live_count        = rcnt_reg;

    // every handle is either free or live, index zero excluded
    `GHT_ASSERT_NOW(a_count_sum, 1'b1, (fc_reg + lt_reg) == CW'(ENTRIES - 1))
    // a result is shown only once the sequencer is back to idle
    `GHT_ASSERT_NOW(a_result_idle, result_valid, !busy)
    // an accepted item either keeps the block busy or answers at once
    `GHT_ASSERT_NEXT(a_accept_prog, start && !busy, busy || result_valid)
    // full is reported only with every usable handle live
    `GHT_ASSERT_NOW(a_full_count, result_valid && (status == STATUS_FULL),
                    live_count == CW'(ENTRIES - 1))

endmodule
